@@ hw/rtl/tdf_pkg.sv @@
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared widths for the trial division factoriser.
// ----------------------------------------------------------------------------
package tdf_pkg;

  // payload widths of the two channels
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned PRIME_W = 31;
  localparam int unsigned EXP_W   = 5;

endpackage

@@ hw/rtl/tdf_value_if.sv @@
// ----------------------------------------------------------------------------
// tdf_value_if
// Input channel: one integer to factor per word.
// ----------------------------------------------------------------------------
interface tdf_value_if;

  logic                        valid;
  logic                        ready;
  logic [tdf_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

@@ hw/rtl/tdf_factor_if.sv @@
// ----------------------------------------------------------------------------
// tdf_factor_if
// Output channel: one distinct prime and its exponent per word.
// ----------------------------------------------------------------------------
interface tdf_factor_if;

  logic                        valid;
  logic                        ready;
  logic [tdf_pkg::PRIME_W-1:0] prime_factor;
  logic [tdf_pkg::EXP_W-1:0]   exponent;
  logic                        last;

  modport source (output valid, output prime_factor, output exponent, output last,
                  input ready);
  modport sink   (input valid, input prime_factor, input exponent, input last,
                  output ready);

endinterface

@@ hw/rtl/trial_division_factorizer_top.sv @@
// ----------------------------------------------------------------------------
// trial_division_factorizer_top
// Factorises one integer by trial division; emits each distinct prime with
// its exponent in ascending order, last word marked.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake      payload
//  value_i    in   valid/ready    value[30:0]
//  factor_o   out  valid/ready    prime_factor[30:0], exponent[4:0], last
//
//  Factors of two are shifted out at one cycle each.
//  Each odd trial divisor costs one VW-bit division by the bit-serial
//  divider (VW = NUM_BITS capped at 31); a 31-bit prime needs about 23000 trials.
//  Inputs 0 and 1 finish in the accept cycle and emit nothing.
//  A stalled output only holds the block when a further factor must be
//  pushed out. Reset is asynchronous, active low, and returns to idle.
//
module trial_division_factorizer_top #(
  parameter int unsigned NUM_BITS = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdf_value_if.sink    value_i,
  tdf_factor_if.source factor_o
);

  localparam int unsigned VW = (NUM_BITS < tdf_pkg::VALUE_W) ? NUM_BITS : tdf_pkg::VALUE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TWO  = 3'd1;
  localparam logic [2:0] S_TRY  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [VW-1:0]               rest_q, rest_d;
  logic [VW-1:0]               div_q, div_d;
  logic [tdf_pkg::EXP_W-1:0]   exp_q, exp_d;

  // one factor held back until we know whether it is the last
  logic                        pend_vld_q, pend_vld_d;
  logic [VW-1:0]               pend_p_q, pend_p_d;
  logic [tdf_pkg::EXP_W-1:0]   pend_e_q, pend_e_d;

  // output register
  logic                        out_vld_q, out_vld_d;
  logic [tdf_pkg::PRIME_W-1:0] out_p_q, out_p_d;
  logic [tdf_pkg::EXP_W-1:0]   out_e_q, out_e_d;
  logic                        out_last_q, out_last_d;

  logic                        div_start;
  logic                        div_done;
  logic [VW-1:0]               div_quot;
  logic [VW-1:0]               div_rem;

  logic                        out_free;
  logic                        push_ok;
  logic [VW-1:0]               new_p;
  logic [tdf_pkg::EXP_W-1:0]   new_e;
  logic [VW-1:0]               in_val;

  tdf_div #(
    .W (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rest_q),
    .divisor_i  (div_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_val        = value_i.value[VW-1:0];
  assign value_i.ready = (state_q == S_IDLE);
  assign out_free      = !out_vld_q || factor_o.ready;
  assign push_ok       = !pend_vld_q || out_free;
  assign div_start     = (state_q == S_TRY);

  // new factor: the leftover prime in the final state, else the divisor
  assign new_p = (state_q == S_FIN) ? rest_q : div_q;
  assign new_e = (state_q == S_FIN) ? tdf_pkg::EXP_W'(1) : exp_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    rest_d     = rest_q;
    div_d      = div_q;
    exp_d      = exp_q;
    pend_vld_d = pend_vld_q;
    pend_p_d   = pend_p_q;
    pend_e_d   = pend_e_q;
    out_vld_d  = out_vld_q && !factor_o.ready;
    out_p_d    = out_p_q;
    out_e_d    = out_e_q;
    out_last_d = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (value_i.valid) begin
          rest_d = in_val;
          exp_d  = '0;
          if (in_val > VW'(1)) begin
            state_d = S_TWO;
          end
        end
      end
      // strip factors of two, one a cycle
      S_TWO: begin
        if (!rest_q[0]) begin
          rest_d = {1'b0, rest_q[VW-1:1]};
          exp_d  = exp_q + 1'b1;
        end else begin
          if (exp_q != '0) begin
            pend_vld_d = 1'b1;
            pend_p_d   = VW'(2);
            pend_e_d   = exp_q;
          end
          exp_d   = '0;
          div_d   = VW'(3);
          state_d = S_TRY;
        end
      end
      S_TRY: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (exp_q != '0) begin
            // repeated division by a known factor
            if (div_rem == '0) begin
              rest_d  = div_quot;
              exp_d   = exp_q + 1'b1;
              state_d = S_TRY;
            end else begin
              state_d = S_PUSH;
            end
          end else if (div_quot < div_q) begin
            // divisor squared exceeds the rest
            state_d = S_FIN;
          end else if (div_rem == '0) begin
            rest_d  = div_quot;
            exp_d   = tdf_pkg::EXP_W'(1);
            state_d = S_TRY;
          end else begin
            div_d   = div_q + VW'(2);
            state_d = S_TRY;
          end
        end
      end
      // move the held factor out and hold the new one
      S_PUSH: begin
        if (push_ok) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_p_d    = tdf_pkg::PRIME_W'(pend_p_q);
            out_e_d    = pend_e_q;
            out_last_d = 1'b0;
          end
          pend_vld_d = 1'b1;
          pend_p_d   = new_p;
          pend_e_d   = new_e;
          exp_d      = '0;
          div_d      = div_q + VW'(2);
          state_d    = S_TRY;
        end
      end
      S_FIN: begin
        if (rest_q > VW'(1)) begin
          if (push_ok) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_p_d    = tdf_pkg::PRIME_W'(pend_p_q);
              out_e_d    = pend_e_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_p_d   = new_p;
            pend_e_d   = new_e;
            rest_d     = VW'(1);
          end
        end else if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_p_d    = tdf_pkg::PRIME_W'(pend_p_q);
          out_e_d    = pend_e_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      exp_q      <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      exp_q      <= exp_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rest_q     <= rest_d;
    div_q      <= div_d;
    pend_p_q   <= pend_p_d;
    pend_e_q   <= pend_e_d;
    out_p_q    <= out_p_d;
    out_e_q    <= out_e_d;
    out_last_q <= out_last_d;
  end

  assign factor_o.valid        = out_vld_q;
  assign factor_o.prime_factor = out_p_q;
  assign factor_o.exponent     = out_e_q;
  assign factor_o.last         = out_last_q;

`ifndef ASSERT_OFF
  // nothing is held back between words
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_vld_q)
    else $error("held factor left over in idle");

  // trial divisors are odd and at least three
  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRY || state_q == S_WAIT) |-> (div_q[0] && div_q >= VW'(3)))
    else $error("bad trial divisor");

  // the divider only reports while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_WAIT)
    else $error("divider finished outside wait");

  // a word leaving carries a non-zero exponent and a prime of at least two
  a_out_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_e_q != '0 && out_p_q >= tdf_pkg::PRIME_W'(2)))
    else $error("malformed factor word");
`endif

endmodule

@@ hw/rtl/tdf_div.sv @@
// ----------------------------------------------------------------------------
// tdf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_div #(
  parameter int unsigned W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;

  logic [W:0]      trial;
  logic [W+1:0]    diff;
  logic            fits;

  // one restoring step: bring down the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign fits  = ~diff[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
